// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property that must hold at every rising edge.
`define VMSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a rising edge.
`define VMSP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/vmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Mode string parser package
// Phase codes, parser state type, character constants and the saturating
// decimal accumulate step.
// ----------------------------------------------------------------------------
package vmsp_pkg;

  localparam int unsigned NumW   = 17;
  localparam int unsigned PrefixLen = 5;

  localparam logic [15:0]           NUM_MAX  = 16'hFFFF;
  localparam logic signed [NumW-1:0] ACC_NONE = '1;

  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_NINE       = 8'h39;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_W          = 8'h57;

  // Expected prefix, one letter per prefix phase.
  localparam logic [7:0] PREFIX_CHARS [PrefixLen] = '{8'h4D, 8'h4F, 8'h44, 8'h45, 8'h5F};

  typedef enum logic [3:0] {
    PH_PREFIX0  = 4'd0,
    PH_PREFIX1  = 4'd1,
    PH_PREFIX2  = 4'd2,
    PH_PREFIX3  = 4'd3,
    PH_PREFIX4  = 4'd4,
    PH_W_FIRST  = 4'd5,
    PH_W_DIGITS = 4'd6,
    PH_H_FIRST  = 4'd7,
    PH_H_DIGITS = 4'd8,
    PH_D_FIRST  = 4'd9,
    PH_D_DIGITS = 4'd10,
    PH_ACCEPT   = 4'd11,
    PH_REJECT   = 4'd12
  } phase_e;

  typedef struct packed {
    phase_e                  phase;
    logic signed [NumW-1:0]  width_acc;
    logic signed [NumW-1:0]  height_acc;
    logic signed [NumW-1:0]  depth_acc;
    logic                    windowed;
  } vmsp_state_t;

  localparam vmsp_state_t STATE_RESET = '{
    phase:      PH_PREFIX0,
    width_acc:  ACC_NONE,
    height_acc: ACC_NONE,
    depth_acc:  ACC_NONE,
    windowed:   1'b0
  };

  // One decimal step: acc * 10 + digit, an unset value counting as zero,
  // saturating at the largest 16-bit value.
  function automatic logic signed [NumW-1:0] acc_digit(input logic signed [NumW-1:0] acc,
                                                       input logic [3:0] digit);
    logic [15:0] base;
    logic [19:0] sum;
    base = acc[NumW-1] ? 16'd0 : acc[15:0];
    sum  = 20'({base, 3'b000}) + 20'({base, 1'b0}) + 20'(digit);
    if (sum > 20'(NUM_MAX)) begin
      return signed'({1'b0, NUM_MAX});
    end
    return signed'({1'b0, sum[15:0]});
  endfunction

endpackage

// ===== rtl/core/vmsp_if.sv =====
// ----------------------------------------------------------------------------
// Mode string parser channels
// Character request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface vmsp_out_if;
  logic               valid;
  logic               ready;
  logic               matched;
  logic signed [16:0] mode_width;
  logic signed [16:0] mode_height;
  logic signed [16:0] color_depth;
  logic               windowed;

  modport source (output valid, output matched, output mode_width, output mode_height,
                  output color_depth, output windowed, input ready);
  modport sink   (input valid, input matched, input mode_width, input mode_height,
                  input color_depth, input windowed, output ready);
endinterface

// ===== rtl/core/vmsp_step.sv =====
// ----------------------------------------------------------------------------
// Mode string parser step
// Next parser state for one character, plus the verdict on that state.
// ----------------------------------------------------------------------------
module vmsp_step
  import vmsp_pkg::*;
(
  input  vmsp_state_t state_i,
  input  logic [7:0]  character_i,
  output vmsp_state_t state_o,
  output logic        matched_o
);

  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] digit_full;

  // Character classification.
  assign is_digit   = (character_i >= CHAR_ZERO) && (character_i <= CHAR_NINE);
  assign digit_full = character_i - CHAR_ZERO;
  assign digit      = digit_full[3:0];

  // Phase transitions and accumulator updates.
  always_comb begin
    state_o = state_i;
    unique case (state_i.phase) inside
      PH_PREFIX0, PH_PREFIX1, PH_PREFIX2, PH_PREFIX3, PH_PREFIX4: begin
        if (character_i == PREFIX_CHARS[state_i.phase[2:0]]) begin
          state_o.phase = phase_e'(state_i.phase + 4'd1);
        end else begin
          state_o.phase = PH_REJECT;
        end
      end
      PH_W_FIRST, PH_W_DIGITS: begin
        if (is_digit) begin
          state_o.width_acc = acc_digit((state_i.phase == PH_W_FIRST) ? ACC_NONE
                                                                      : state_i.width_acc, digit);
          state_o.phase     = PH_W_DIGITS;
        end else if (state_i.phase == PH_W_DIGITS && character_i == CHAR_UNDERSCORE) begin
          state_o.phase = PH_H_FIRST;
        end else begin
          state_o.phase = PH_REJECT;
        end
      end
      PH_H_FIRST, PH_H_DIGITS: begin
        if (is_digit) begin
          state_o.height_acc = acc_digit((state_i.phase == PH_H_FIRST) ? ACC_NONE
                                                                       : state_i.height_acc, digit);
          state_o.phase      = PH_H_DIGITS;
        end else if (state_i.phase == PH_H_DIGITS && character_i == CHAR_UNDERSCORE) begin
          state_o.phase = PH_D_FIRST;
        end else begin
          state_o.phase = PH_REJECT;
        end
      end
      PH_D_FIRST: begin
        if (is_digit) begin
          state_o.depth_acc = acc_digit(ACC_NONE, digit);
          state_o.phase     = PH_D_DIGITS;
        end else begin
          state_o.phase = PH_REJECT;
        end
      end
      PH_D_DIGITS: begin
        if (is_digit) begin
          state_o.depth_acc = acc_digit(state_i.depth_acc, digit);
        end else begin
          // A terminator or any other byte closes the depth and accepts.
          if (character_i == CHAR_W) begin
            state_o.windowed = 1'b1;
          end
          state_o.phase = PH_ACCEPT;
        end
      end
      PH_ACCEPT: begin
        state_o.phase = PH_ACCEPT;
      end
      default: begin
        state_o.phase = PH_REJECT;
      end
    endcase
  end

  // The string counts as matched once the depth digits have started.
  assign matched_o = (state_o.phase == PH_D_DIGITS) || (state_o.phase == PH_ACCEPT);

endmodule

// ===== rtl/core/video_mode_string_parser_core.sv =====
// Path: a last character is held in the input register, and its result is
// loaded into the result register once the result register has room.
// Throughput: one character per cycle through a single combinational parser step;
// only a last character waits, and only while an earlier result is still held.
// Reset: asynchronous, active low; parser state returns to the first prefix
// letter with all numbers unset, and both pipeline registers are emptied.
// ----------------------------------------------------------------------------
// Video mode string parser core
// Input register, one-step parser on the held character, and a result
// register that is loaded when the character flagged as last is consumed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module video_mode_string_parser_core
  import vmsp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  vmsp_in_if.sink         in_req,
  vmsp_out_if.source      out_res
);

  logic        s1_valid_q;
  logic [7:0]  s1_char_q;
  logic        s1_last_q;
  logic        s1_fire;
  logic        out_free;
  logic        in_fire;

  vmsp_state_t state_q;
  vmsp_state_t state_d;
  vmsp_state_t step_state;
  logic        step_matched;

  logic               out_valid_q;
  logic               out_matched_q;
  logic signed [16:0] out_width_q;
  logic signed [16:0] out_height_q;
  logic signed [16:0] out_depth_q;
  logic               out_windowed_q;

  logic        res_load;
  logic        match_unset;
  logic        acc_bad;

  // Handshake: only a last character needs room in the result register.
  assign out_free     = !out_valid_q || out_res.ready;
  assign s1_fire      = s1_valid_q && (!s1_last_q || out_free);
  assign in_req.ready = !s1_valid_q || s1_fire;
  assign in_fire      = in_req.valid && in_req.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_q <= in_req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= in_req.character;
      s1_last_q <= in_req.last;
    end
  end

  // Parser step on the held character.
  vmsp_step u_step (
    .state_i     (state_q),
    .character_i (s1_char_q),
    .state_o     (step_state),
    .matched_o   (step_matched)
  );

  // Parser state: cleared after each string's result.
  always_comb begin
    state_d = state_q;
    if (s1_fire) begin
      state_d = s1_last_q ? STATE_RESET : step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_matched_q  <= step_matched;
      out_width_q    <= step_state.width_acc;
      out_height_q   <= step_state.height_acc;
      out_depth_q    <= step_state.depth_acc;
      out_windowed_q <= step_state.windowed;
    end
  end

  assign out_res.valid       = out_valid_q;
  assign out_res.matched     = out_matched_q;
  assign out_res.mode_width  = out_width_q;
  assign out_res.mode_height = out_height_q;
  assign out_res.color_depth = out_depth_q;
  assign out_res.windowed    = out_windowed_q;

  // Conditions watched by the checks below.
  assign res_load    = s1_fire && s1_last_q;
  assign match_unset = out_valid_q && out_matched_q &&
                       (out_width_q[16] || out_height_q[16] || out_depth_q[16]);
  assign acc_bad     = (state_q.width_acc[16] && !(&state_q.width_acc)) ||
                       (state_q.height_acc[16] && !(&state_q.height_acc)) ||
                       (state_q.depth_acc[16] && !(&state_q.depth_acc));

  // Checks on parser and pipeline behaviour.
  `VMSP_ASSERT(a_clear_after_last, res_load |=> (state_q == STATE_RESET), "state not cleared")
  `VMSP_ASSERT(a_rose_from_last, $rose(out_valid_q) |-> $past(res_load), "result without last")
  `VMSP_ASSERT_NEVER(a_match_has_numbers, match_unset, "matched result with an unset number")
  `VMSP_ASSERT_NEVER(a_acc_range, acc_bad, "accumulator out of range")

endmodule

// ===== tb/sv/video_mode_string_parser_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mode string parser core testbench
// Sends mode strings one character per request. A directed table comes first,
// then random strings: mostly well-formed, with saturating numbers, trailing
// bytes, terminators, corrupted bytes, early ends and pure noise. Each result
// is checked field by field against its table row or an in-bench parser model,
// with random idling on the request side and stalls on the result side.
// ----------------------------------------------------------------------------
module video_mode_string_parser_core_test;
  import vmsp_pkg::*;

  // One result of the block, as the parser model predicts it.
  typedef struct packed {
    logic                   matched;
    logic signed [NumW-1:0] mode_width;
    logic signed [NumW-1:0] mode_height;
    logic signed [NumW-1:0] color_depth;
    logic                   windowed;
  } mode_result_t;

  // One row of the directed table; typed rows carry the result written in.
  typedef struct packed {
    logic [7:0]   ch;
    logic         fin;
    logic         typed;
    mode_result_t res;
  } dir_row_t;

  typedef enum int {
    LN_CLEAN, LN_SATURATE, LN_TRAILING, LN_NUL, LN_CORRUPT, LN_TRUNCATE, LN_NOISE
  } line_kind_e;

  typedef enum int {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_CHOKED} rx_mode_e;

  localparam int unsigned CharTarget = 1300;
  localparam int unsigned DirLen     = 21;

  localparam mode_result_t UNSET_MODE = '{1'b0, ACC_NONE, ACC_NONE, ACC_NONE, 1'b0};

  localparam dir_row_t DIR_ROWS [DirLen] = '{
    '{8'h00, 1'b1, 1'b1, UNSET_MODE},   // terminator as the whole string
    '{8'hFF, 1'b1, 1'b1, UNSET_MODE},   // top byte value, rejected at once
    '{"M",   1'b0, 1'b0, UNSET_MODE},
    '{"X",   1'b1, 1'b1, UNSET_MODE},   // broken prefix
    '{"M",   1'b0, 1'b0, UNSET_MODE},
    '{"O",   1'b0, 1'b0, UNSET_MODE},
    '{"D",   1'b0, 1'b0, UNSET_MODE},
    '{"E",   1'b0, 1'b0, UNSET_MODE},
    '{"_",   1'b0, 1'b0, UNSET_MODE},
    '{"9",   1'b0, 1'b0, UNSET_MODE},
    '{"_",   1'b0, 1'b0, UNSET_MODE},
    '{"0",   1'b0, 1'b0, UNSET_MODE},
    '{"_",   1'b0, 1'b0, UNSET_MODE},
    '{"1",   1'b0, 1'b0, UNSET_MODE},
    '{"W",   1'b1, 1'b1, '{1'b1, 17'sd9, 17'sd0, 17'sd1, 1'b1}},
    '{"M",   1'b0, 1'b0, UNSET_MODE},
    '{"O",   1'b0, 1'b0, UNSET_MODE},
    '{"D",   1'b0, 1'b0, UNSET_MODE},
    '{"E",   1'b0, 1'b0, UNSET_MODE},
    '{"_",   1'b0, 1'b0, UNSET_MODE},
    '{"7",   1'b1, 1'b1, '{1'b0, 17'sd7, ACC_NONE, ACC_NONE, 1'b0}}  // ends inside width
  };

  logic clk_i;
  logic rst_ni;

  vmsp_in_if  req_ch ();
  vmsp_out_if res_ch ();

  video_mode_string_parser_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  vmsp_state_t  parse_st;
  mode_result_t pending_modes [$];
  logic [7:0]   line_buf [$];
  int           burst_left;
  int           fail_count;
  int           chars_sent;
  int           lines_sent;
  int           results_seen;
  int           matched_seen;
  int           windowed_seen;
  int           saturated_seen;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // One decimal digit into an accumulator; an unset value counts as zero.
  function automatic logic signed [NumW-1:0] add_digit(input logic signed [NumW-1:0] acc,
                                                       input logic [7:0] c);
    int base;
    int v;
    base = acc[NumW-1] ? 0 : int'(acc[15:0]);
    v    = base * 10 + int'(c) - int'(CHAR_ZERO);
    if (v > int'(NUM_MAX)) begin
      v = int'(NUM_MAX);
    end
    return NumW'(v);
  endfunction

  // Parser model: advances the phase and numbers by one character.
  function automatic void step_parser(input logic [7:0] c);
    logic is_num;
    is_num = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    case (parse_st.phase)
      PH_PREFIX0, PH_PREFIX1, PH_PREFIX2, PH_PREFIX3, PH_PREFIX4: begin
        parse_st.phase = (c == PREFIX_CHARS[int'(parse_st.phase)]) ?
                         phase_e'(parse_st.phase + 4'd1) : PH_REJECT;
      end
      PH_W_FIRST, PH_W_DIGITS: begin
        if (is_num) begin
          parse_st.width_acc = add_digit(parse_st.phase == PH_W_FIRST ? ACC_NONE :
                                         parse_st.width_acc, c);
          parse_st.phase = PH_W_DIGITS;
        end else begin
          parse_st.phase = (parse_st.phase == PH_W_DIGITS && c == CHAR_UNDERSCORE) ?
                           PH_H_FIRST : PH_REJECT;
        end
      end
      PH_H_FIRST, PH_H_DIGITS: begin
        if (is_num) begin
          parse_st.height_acc = add_digit(parse_st.phase == PH_H_FIRST ? ACC_NONE :
                                          parse_st.height_acc, c);
          parse_st.phase = PH_H_DIGITS;
        end else begin
          parse_st.phase = (parse_st.phase == PH_H_DIGITS && c == CHAR_UNDERSCORE) ?
                           PH_D_FIRST : PH_REJECT;
        end
      end
      PH_D_FIRST: begin
        if (is_num) begin
          parse_st.depth_acc = add_digit(ACC_NONE, c);
          parse_st.phase = PH_D_DIGITS;
        end else begin
          parse_st.phase = PH_REJECT;
        end
      end
      PH_D_DIGITS: begin
        // Any non-digit closes the depth; a terminator or junk still accepts.
        if (is_num) begin
          parse_st.depth_acc = add_digit(parse_st.depth_acc, c);
        end else begin
          if (c == CHAR_W) begin
            parse_st.windowed = 1'b1;
          end
          parse_st.phase = PH_ACCEPT;
        end
      end
      PH_ACCEPT: begin
      end
      default: begin
        parse_st.phase = PH_REJECT;
      end
    endcase
  endfunction

  // Drives one character request in bursts, then updates the parser model.
  task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                           input mode_result_t typed_res);
    mode_result_t want;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(1, 16);
    end
    req_ch.valid     <= 1'b1;
    req_ch.character <= c;
    req_ch.last      <= fin;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    burst_left--;
    chars_sent++;
    step_parser(c);
    if (fin) begin
      want.matched     = (parse_st.phase == PH_D_DIGITS) || (parse_st.phase == PH_ACCEPT);
      want.mode_width  = parse_st.width_acc;
      want.mode_height = parse_st.height_acc;
      want.color_depth = parse_st.depth_acc;
      want.windowed    = parse_st.windowed;
      pending_modes.push_back(typed ? typed_res : want);
      parse_st = STATE_RESET;
      lines_sent++;
    end
  endtask

  // Holds the request side idle until every pending result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_modes.size() != 0);
  endtask

  // Appends a decimal number; a wide one is likely to saturate.
  function automatic void put_number(input bit wide);
    int n;
    n = wide ? $urandom_range(5, 8) : $urandom_range(1, 5);
    repeat (n) begin
      if (wide && $urandom_range(0, 1) == 0) begin
        line_buf.push_back(CHAR_NINE);
      end else begin
        line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
    end
  endfunction

  // Builds one random string of the given kind into the line buffer.
  function automatic void build_line(input line_kind_e kind);
    string head;
    int    sat_pick;
    int    idx;
    head = "MODE_";
    line_buf.delete();
    if (kind == LN_NOISE) begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    sat_pick = (kind == LN_SATURATE) ? $urandom_range(0, 2) : 3;
    foreach (head[i]) line_buf.push_back(head[i]);
    put_number(sat_pick == 0);
    line_buf.push_back(CHAR_UNDERSCORE);
    put_number(sat_pick == 1);
    line_buf.push_back(CHAR_UNDERSCORE);
    put_number(sat_pick == 2);
    if ($urandom_range(0, 1) == 0) begin
      line_buf.push_back(CHAR_W);
    end
    // Bytes after the depth's closing non-digit, including further digits and 'W's, are ignored.
    if (kind == LN_TRAILING || kind == LN_NUL) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0:       line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
          1:       line_buf.push_back(CHAR_W);
          default: line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    idx = $urandom_range(0, line_buf.size() - 1);
    case (kind)
      LN_NUL:      line_buf[idx] = 8'h00;
      LN_CORRUPT:  line_buf[idx] = 8'($urandom_range(0, 255));
      LN_TRUNCATE: begin
        while (line_buf.size() > idx + 1) void'(line_buf.pop_back());
      end
      default: begin
      end
    endcase
  endfunction

  // Stimulus: reset, the directed table, then random strings.
  initial begin
    line_kind_e kind;
    int         pick;
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.character = 8'h00;
    req_ch.last      = 1'b0;
    parse_st         = STATE_RESET;
    burst_left       = 0;
    fail_count       = 0;
    chars_sent       = 0;
    lines_sent       = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirLen; r++) begin
      send_char(DIR_ROWS[r].ch, DIR_ROWS[r].fin, DIR_ROWS[r].typed, DIR_ROWS[r].res);
    end
    drain_results();

    // Mostly well-formed strings; the first few walk through every kind once.
    for (int n = 0; chars_sent < CharTarget; n++) begin
      if (n <= int'(LN_NOISE)) begin
        kind = line_kind_e'(n);
      end else begin
        pick = $urandom_range(0, 99);
        kind = (pick < 40) ? LN_CLEAN    : (pick < 52) ? LN_SATURATE :
               (pick < 64) ? LN_TRAILING : (pick < 74) ? LN_NUL      :
               (pick < 84) ? LN_CORRUPT  : (pick < 92) ? LN_TRUNCATE : LN_NOISE;
      end
      build_line(kind);
      foreach (line_buf[i]) begin
        send_char(line_buf[i], i == line_buf.size() - 1, 1'b0, UNSET_MODE);
      end
      if ($urandom_range(0, 24) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d characters in %0d mode strings of every kind, with random idling.",
             chars_sent, lines_sent);
    $display("Checked %0d results: %0d matched, %0d windowed, %0d saturated.",
             results_seen, matched_seen, windowed_seen, saturated_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side stalls: the pattern is redrawn at random from open, sparse, periodic and choked.
  initial begin
    rx_mode_e rx_mode;
    int       mode_left;
    int       cyc;
    res_ch.ready = 1'b0;
    rx_mode      = RX_OPEN;
    mode_left    = 0;
    cyc          = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:     res_ch.ready <= 1'b1;
        RX_SPARSE:   res_ch.ready <= ($urandom_range(0, 2) == 0);
        RX_PERIODIC: res_ch.ready <= ((cyc % 7) >= 5);
        default:     res_ch.ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    mode_result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (pending_modes.size() == 0) begin
        $error("result arrived with no request pending");
        fail_count++;
      end else begin
        want = pending_modes.pop_front();
        if (want.matched) matched_seen++;
        if (want.windowed) windowed_seen++;
        if (want.mode_width == 17'sd65535 || want.mode_height == 17'sd65535 ||
            want.color_depth == 17'sd65535) begin
          saturated_seen++;
        end
        if (res_ch.matched !== want.matched) begin
          $error("matched: expected %0d, got %0d", want.matched, res_ch.matched);
          fail_count++;
        end
        if (res_ch.mode_width !== want.mode_width) begin
          $error("mode_width: expected %0d, got %0d", want.mode_width, res_ch.mode_width);
          fail_count++;
        end
        if (res_ch.mode_height !== want.mode_height) begin
          $error("mode_height: expected %0d, got %0d", want.mode_height, res_ch.mode_height);
          fail_count++;
        end
        if (res_ch.color_depth !== want.color_depth) begin
          $error("color_depth: expected %0d, got %0d", want.color_depth, res_ch.color_depth);
          fail_count++;
        end
        if (res_ch.windowed !== want.windowed) begin
          $error("windowed: expected %0d, got %0d", want.windowed, res_ch.windowed);
          fail_count++;
        end
      end
    end
  end

  // Guard against a hang.
  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
